// File: hw/rtl/chm_pkg.sv
// Shared constants and types for the coverage histogram median block.
// Depends on nothing; used by chm_bin_ram and coverage_histogram_median.

package chm_pkg;

    localparam int TOP_VALUE_DEF  = 65535;
    localparam int COUNT_BITS_DEF = 32;

    localparam int COVERAGE_BITS = 31;
    localparam int S_DATA_BITS   = 32;
    localparam int MEDIAN_BITS   = 16;
    localparam int REPORT_BITS   = 32;
    localparam int M_DATA_BITS   = MEDIAN_BITS + REPORT_BITS;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_WRITE,
        ST_SCAN,
        ST_REPORT
    } chm_state_t;

endpackage

// File: hw/rtl/chm_bin_ram.sv
// Histogram bin store: one write port and one registered read port.
// Depends on chm_pkg for default sizes only.

module chm_bin_ram #(
    parameter int DEPTH     = chm_pkg::TOP_VALUE_DEF + 1,
    parameter int ADDR_BITS = $clog2(DEPTH),
    parameter int DATA_BITS = chm_pkg::COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/coverage_histogram_median.sv
// Coverage histogram median: top level with sequencer, accumulator and output register.
// Depends on chm_pkg and chm_bin_ram.
// Add request: accepted, then a read-modify-write of its bin in ST_ADD_WRITE; ready again back in ST_IDLE.
// Finish request: scan of TOP_VALUE+1 bins through the single bin RAM read port,
// clearing each bin as it is read; result registered in ST_REPORT, s_tready
// low until then and for as long as an unaccepted earlier result holds the output register.
// Reset (aresetn low, synchronous): clearing pass over all TOP_VALUE+1 bins, s_tready low.

module coverage_histogram_median #(
    parameter int TOP_VALUE  = chm_pkg::TOP_VALUE_DEF,
    parameter int COUNT_BITS = chm_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [chm_pkg::S_DATA_BITS-1:0]  s_tdata,   // [30:0] coverage
    input  logic                             s_tuser,   // [0] command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [chm_pkg::M_DATA_BITS-1:0]  m_tdata    // [15:0] median_value, [47:16] sample_count
);

    localparam int DEPTH     = TOP_VALUE + 1;
    localparam int ADDR_BITS = $clog2(DEPTH);
    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(TOP_VALUE);

    chm_pkg::chm_state_t state_reg, state_next;

    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic                  issue_reg, issue_next;
    logic                  pend_reg, pend_next;
    logic [ADDR_BITS-1:0]  pend_addr_reg, pend_addr_next;
    logic [ADDR_BITS-1:0]  bin_reg, bin_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [COUNT_BITS-1:0] half_reg, half_next;
    logic [COUNT_BITS-1:0] acc_reg, acc_next;
    logic                  found_reg, found_next;
    logic [ADDR_BITS-1:0]  median_reg, median_next;
    logic                  m_valid_reg, m_valid_next;
    logic [chm_pkg::M_DATA_BITS-1:0] m_data_reg, m_data_next;

    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [ADDR_BITS-1:0]  rd_addr;
    logic [COUNT_BITS-1:0] rd_data;

    logic                  s_accept;
    logic [ADDR_BITS-1:0]  s_bin;
    logic [COUNT_BITS:0]   acc_sum;
    logic [COUNT_BITS-1:0] acc_sat;
    logic [63:0]           total_wide;
    logic [chm_pkg::REPORT_BITS-1:0] report_count;

    chm_bin_ram #(
        .DEPTH     (DEPTH),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (COUNT_BITS)
    ) u_bin_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == chm_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign s_bin    = (s_tdata[chm_pkg::COVERAGE_BITS-1:0] >
                       chm_pkg::COVERAGE_BITS'(TOP_VALUE))
                      ? LAST_ADDR : s_tdata[ADDR_BITS-1:0];

    assign acc_sum    = {1'b0, acc_reg} + {1'b0, rd_data};
    assign acc_sat    = acc_sum[COUNT_BITS] ? '1 : acc_sum[COUNT_BITS-1:0];
    assign total_wide = 64'(total_reg);
    assign report_count = (total_wide > 64'hFFFF_FFFF) ? '1
                          : total_wide[chm_pkg::REPORT_BITS-1:0];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= chm_pkg::ST_CLEAR;
            addr_reg    <= '0;
            issue_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            total_reg   <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            total_reg   <= total_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
        bin_reg       <= bin_next;
        half_reg      <= half_next;
        acc_reg       <= acc_next;
        median_reg    <= median_next;
        m_data_reg    <= m_data_next;
    end

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        bin_next       = bin_reg;
        total_next     = total_reg;
        half_next      = half_reg;
        acc_next       = acc_reg;
        found_next     = found_reg;
        median_next    = median_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        wr_en          = 1'b0;
        wr_addr        = addr_reg;
        wr_data        = '0;
        rd_addr        = s_bin;

        case (state_reg)
            chm_pkg::ST_CLEAR: begin
                wr_en = 1'b1;
                if (addr_reg == LAST_ADDR) begin
                    addr_next  = '0;
                    state_next = chm_pkg::ST_IDLE;
                end else begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            chm_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == chm_pkg::CMD_ADD) begin
                        bin_next   = s_bin;
                        state_next = chm_pkg::ST_ADD_WRITE;
                    end else begin
                        half_next  = (total_reg >> 1) + COUNT_BITS'(total_reg[0]);
                        acc_next   = '0;
                        found_next = 1'b0;
                        addr_next  = '0;
                        issue_next = 1'b1;
                        state_next = chm_pkg::ST_SCAN;
                    end
                end
            end
            chm_pkg::ST_ADD_WRITE: begin
                wr_en      = 1'b1;
                wr_addr    = bin_reg;
                wr_data    = (&rd_data) ? rd_data : rd_data + 1'b1;
                total_next = (&total_reg) ? total_reg : total_reg + 1'b1;
                state_next = chm_pkg::ST_IDLE;
            end
            chm_pkg::ST_SCAN: begin
                rd_addr = addr_reg;
                if (issue_reg) begin
                    pend_next      = 1'b1;
                    pend_addr_next = addr_reg;
                    if (addr_reg == LAST_ADDR) begin
                        issue_next = 1'b0;
                    end else begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
                if (pend_reg) begin
                    wr_en    = 1'b1;
                    wr_addr  = pend_addr_reg;
                    acc_next = acc_sat;
                    if (!found_reg && (acc_sat >= half_reg)) begin
                        found_next  = 1'b1;
                        median_next = pend_addr_reg;
                    end
                    if (pend_addr_reg == LAST_ADDR) begin
                        if (!found_reg && !(acc_sat >= half_reg)) begin
                            median_next = LAST_ADDR;
                        end
                        state_next = chm_pkg::ST_REPORT;
                    end
                end
            end
            chm_pkg::ST_REPORT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {report_count, chm_pkg::MEDIAN_BITS'(median_reg)};
                    total_next   = '0;
                    addr_next    = '0;
                    state_next   = chm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = chm_pkg::ST_CLEAR;
                addr_next  = '0;
            end
        endcase
    end

endmodule

// File: tb/coverage_histogram_median_tb.sv
// Testbench for coverage_histogram_median: directed and random coverage sets, each
// closed by a finish request, checked against a histogram model of the lower median.
// Depends on chm_pkg and the coverage_histogram_median RTL.
`timescale 1ns / 100ps

module coverage_histogram_median_tb;

    localparam int TOP = chm_pkg::TOP_VALUE_DEF;
    localparam longint unsigned COUNT_MAX =
        64'hFFFF_FFFF_FFFF_FFFF >> (64 - chm_pkg::COUNT_BITS_DEF);
    localparam longint unsigned REPORT_MAX = 64'h0000_0000_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 400_000_000;
    localparam int RANDOM_ITEMS = 1400;
    localparam int RANDOM_REPORTS = 30;

    typedef struct packed {
        logic [chm_pkg::MEDIAN_BITS-1:0] median;
        logic [chm_pkg::REPORT_BITS-1:0] count;
    } report_t;

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [chm_pkg::S_DATA_BITS-1:0]  s_tdata;   // [30:0] coverage
    logic                             s_tuser;   // [0] command
    logic                             m_tvalid;
    logic                             m_tready;
    logic [chm_pkg::M_DATA_BITS-1:0]  m_tdata;   // [15:0] median_value, [47:16] sample_count

    longint unsigned hist_bins[int];
    longint unsigned hist_total;
    report_t         pending_reports[$];
    report_t         want_report;
    int              error_count;
    int              cycle_count;
    int              items_sent;
    int              reports_made;
    bit              sender_burst;

    coverage_histogram_median dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint unsigned sat_inc(longint unsigned v);
        return (v >= COUNT_MAX) ? COUNT_MAX : v + 1;
    endfunction

    function automatic logic [chm_pkg::MEDIAN_BITS-1:0] lower_median();
        longint unsigned half;
        longint unsigned acc;
        int              k;
        half = (hist_total >> 1) + (hist_total & 1);
        acc  = 0;
        if (half == 0)
            return '0;
        if (hist_bins.first(k)) begin
            do begin
                acc = (acc > 64'hFFFF_FFFF_FFFF_FFFF - hist_bins[k]) ?
                      64'hFFFF_FFFF_FFFF_FFFF : acc + hist_bins[k];
                if (acc >= half)
                    return k[chm_pkg::MEDIAN_BITS-1:0];
            end while (hist_bins.next(k));
        end
        return TOP[chm_pkg::MEDIAN_BITS-1:0];
    endfunction

    function automatic void histogram_update(logic cmd, logic [30:0] cov);
        report_t r;
        int      bin;
        if (cmd == chm_pkg::CMD_ADD) begin
            bin = (cov > TOP) ? TOP : int'(cov);
            hist_bins[bin] = sat_inc(hist_bins.exists(bin) ? hist_bins[bin] : 0);
            hist_total = sat_inc(hist_total);
        end else begin
            r.median = lower_median();
            r.count  = (hist_total > REPORT_MAX) ? REPORT_MAX[31:0] : hist_total[31:0];
            pending_reports.push_back(r);
            hist_bins.delete();
            hist_total = 0;
        end
    endfunction

    function automatic int unsigned idle_length();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (sender_burst || pick < 12)
            return 0;
        if (pick < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_request(logic cmd, logic [30:0] cov);
        int unsigned gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, cov};
        do @(posedge aclk); while (s_tready !== 1'b1);
        histogram_update(cmd, cov);
        items_sent++;
        if (cmd == chm_pkg::CMD_FINISH)
            reports_made++;
        gap = idle_length();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tuser  <= 1'($urandom_range(0, 1));
            s_tdata  <= {1'b0, 31'($urandom)};
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic add_coverage(logic [30:0] cov);
        send_request(chm_pkg::CMD_ADD, cov);
    endtask

    task automatic finish_set();
        send_request(chm_pkg::CMD_FINISH, 31'($urandom));
    endtask

    function automatic logic [30:0] random_coverage();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 10)
            return 31'($urandom_range(0, 15));
        if (pick < 15)
            return 31'($urandom_range(0, TOP));
        if (pick < 17)
            return 31'($urandom_range(TOP - 5, TOP + 5));
        return 31'($urandom);
    endfunction

    task automatic test_empty_set();
        finish_set();
        finish_set();
    endtask

    task automatic test_single_value();
        add_coverage(31'd0);
        finish_set();
        add_coverage(31'(TOP));
        finish_set();
        add_coverage(31'(TOP + 1));
        finish_set();
        add_coverage(31'h7FFF_FFFF);
        finish_set();
    endtask

    task automatic test_odd_even_sets();
        add_coverage(31'd3);
        add_coverage(31'd1);
        add_coverage(31'd2);
        finish_set();
        add_coverage(31'd5);
        add_coverage(31'd3);
        finish_set();
    endtask

    task automatic test_clamped_values();
        add_coverage(31'h5555_5555);
        add_coverage(31'h2AAA_AAAA);
        add_coverage(31'h0001_0000);
        add_coverage(31'd1234);
        finish_set();
    endtask

    task automatic test_random_sets();
        int unsigned pick;
        int unsigned set_len;
        while (items_sent < RANDOM_ITEMS || reports_made < RANDOM_REPORTS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                set_len = 0;
            else if (pick == 19)
                set_len = 1;
            else if (pick < 16)
                set_len = $urandom_range(2, 60);
            else
                set_len = $urandom_range(61, 150);
            sender_burst = ($urandom_range(0, 3) == 0);
            repeat (set_len) add_coverage(random_coverage());
            finish_set();
        end
        sender_burst = 1'b0;
    endtask

    initial begin
        int unsigned run;
        int unsigned stall;
        m_tready = 1'b0;
        forever begin
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 2000) :
                                                $urandom_range(1, 40);
            repeat (run) @(negedge aclk) m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                stall = $urandom_range(20, 150);
            else
                stall = $urandom_range(0, 3);
            repeat (stall) @(negedge aclk) m_tready <= 1'b0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t unexpected report: expected none, actual median %0d count %0d",
                         $time, m_tdata[15:0], m_tdata[47:16]);
                error_count++;
            end else begin
                want_report = pending_reports.pop_front();
                if (m_tdata[15:0] !== want_report.median) begin
                    $display("%0t median_value: expected %0d, actual %0d",
                             $time, want_report.median, m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[47:16] !== want_report.count) begin
                    $display("%0t sample_count: expected %0d, actual %0d",
                             $time, want_report.count, m_tdata[47:16]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        hist_total   = 0;
        error_count  = 0;
        items_sent   = 0;
        reports_made = 0;
        sender_burst = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_set();
        test_single_value();
        test_odd_even_sets();
        test_clamped_values();
        items_sent   = 0;
        reports_made = 0;
        test_random_sets();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/chm_pkg.sv
hw/rtl/chm_bin_ram.sv
hw/rtl/coverage_histogram_median.sv
tb/coverage_histogram_median_tb.sv
